### rtl/core/rau_pkg.sv
package rau_pkg;

  // Operation selector carried in the low bits of the input tdata.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // Function of the shared adder.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  // Status the shared adder reports back to the sequencer.
  typedef struct packed {
    logic borrow;  // Subtraction went below zero.
    logic zero;    // Result is all zeros.
  } alu_flags_t;

endpackage

### rtl/core/rau_alu.sv
module rau_alu #(
  parameter int WIDTH = 33
) (
  input  logic [WIDTH-1:0]     a_i,
  input  logic [WIDTH-1:0]     b_i,
  input  rau_pkg::alu_op_e     op_i,
  output logic [WIDTH-1:0]     res_o,
  output rau_pkg::alu_flags_t  flags_o
);

  logic             is_sub;
  logic [WIDTH-1:0] b_eff;
  logic             carry;

  // One carry chain serves both add and subtract; subtract adds the inverted operand plus one.
  assign is_sub = (op_i == rau_pkg::ALU_SUB);
  assign b_eff  = is_sub ? ~b_i : b_i;
  assign {carry, res_o} = {1'b0, a_i} + {1'b0, b_eff} + {{WIDTH{1'b0}}, is_sub};

  // A missing carry out of a subtraction means a borrow.
  assign flags_o.borrow = is_sub & ~carry;
  assign flags_o.zero   = (res_o == '0);

endmodule

### rtl/core/rau_mul.sv
module rau_mul #(
  parameter int OPERAND_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [OPERAND_BITS-1:0]   a_i,
  input  logic [OPERAND_BITS-1:0]   b_i,
  output logic [2*OPERAND_BITS-1:0] p_o
);

  logic [2*OPERAND_BITS-1:0] p_q;

  // Unsigned magnitude product, registered and held while not enabled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

### rtl/core/rational_arithmetic_unit_top.sv
// Channel   Direction  tdata (low bit up)                           tuser
// s_axis    in         op[2], a_num[N], a_den[N], b_num[N], b_den[N]  -
// m_axis    out        res_num[2N+1], res_den[2N-1]                  undefined
// (N = OPERAND_BITS, tdata padded with zeros to whole bytes.)
//
// One transaction runs the products and the sum, then the binary gcd, one halving,
// subtraction or swap per step, then one shift per common factor of two, then the
// two restoring divisions; the sum, the gcd, both divisions and the final negation
// share one adder, and the products share one multiplier.
// s_axis_tready is high only while the sequencer is idle. A finished result
// waits in the output register, so the next transaction may start while
// m_axis_tready is low; the sequencer holds its next result until that register
// frees. Reset clears the sequencer and the output valid; no clearing pass.
module rational_arithmetic_unit_top #(
  parameter int OPERAND_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // op, a_num, a_den, b_num, b_den
  input  logic [((4*OPERAND_BITS+2+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // res_num, res_den
  output logic [((4*OPERAND_BITS+7)/8)*8-1:0]      m_axis_tdata,
  // undefined
  output logic                                     m_axis_tuser
);

  localparam int W       = OPERAND_BITS;
  localparam int MW      = 2 * OPERAND_BITS;
  localparam int AW      = MW + 1;
  localparam int DEN_W   = 2 * OPERAND_BITS - 1;
  localparam int OUT_PAD = ((4 * OPERAND_BITS + 7) / 8) * 8;
  localparam int KW      = $clog2(MW);
  localparam int CW      = $clog2(MW + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_M1    = 4'd1;
  localparam logic [3:0] ST_M2    = 4'd2;
  localparam logic [3:0] ST_M3    = 4'd3;
  localparam logic [3:0] ST_ADD   = 4'd4;
  localparam logic [3:0] ST_ADD2  = 4'd5;
  localparam logic [3:0] ST_GINIT = 4'd6;
  localparam logic [3:0] ST_GCD   = 4'd7;
  localparam logic [3:0] ST_SHL   = 4'd8;
  localparam logic [3:0] ST_DIVN  = 4'd9;
  localparam logic [3:0] ST_DIVD  = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  logic [3:0] state_q, state_d;
  logic [KW-1:0] k_q, k_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic m_valid_q, m_valid_d;

  rau_pkg::op_e op_q, op_d;
  logic san_q, sad_q, sbn_q, sbd_q;
  logic san_d, sad_d, sbn_d, sbd_d;
  logic [W-1:0] man_q, mad_q, mbn_q, mbd_q;
  logic [W-1:0] man_d, mad_d, mbn_d, mbd_d;
  logic sn_q, sn_d, sd_q, sd_d;
  logic [MW-1:0] mn_q, mn_d, md_q, md_d;
  logic [MW-1:0] x_q, x_d, y_q, y_d;
  logic [MW-1:0] rem_q, rem_d;
  logic [OUT_PAD-1:0] m_data_q, m_data_d;
  logic m_user_q, m_user_d;

  logic [W-1:0] in_an, in_ad, in_bn, in_bd;
  logic in_accept;
  logic out_load;

  logic mul_en;
  logic [W-1:0] mul_a, mul_b;
  logic [MW-1:0] prod;

  logic [AW-1:0] alu_a, alu_b, alu_res;
  rau_pkg::alu_op_e alu_op;
  rau_pkg::alu_flags_t alu_flags;

  logic t2s;
  logic div_bit;
  logic [AW-1:0] num_out;

  // Input field slices.
  assign in_an = s_axis_tdata[2 +: W];
  assign in_ad = s_axis_tdata[2 + W +: W];
  assign in_bn = s_axis_tdata[2 + 2*W +: W];
  assign in_bd = s_axis_tdata[2 + 3*W +: W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign out_load      = (state_q == ST_DONE) & (~m_valid_q | m_axis_tready);

  // Shared multiplier for the three cross products.
  rau_mul #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_mul (
    .clk_i(clk_i),
    .en_i (mul_en),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  // Shared adder for the sum, the gcd loop, both divisions and the final negation.
  rau_alu #(
    .WIDTH(AW)
  ) u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .op_i   (alu_op),
    .res_o  (alu_res),
    .flags_o(alu_flags)
  );

  // Sign of the second cross product, flipped for subtraction.
  assign t2s = (prod != '0) & (sbn_q ^ sad_q ^ (op_q == rau_pkg::OP_SUB));

  // Quotient bit of the current restoring step.
  assign div_bit = ~alu_flags.borrow;

  // Operand selection for the multiplier and the adder.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = man_q;
    mul_b  = mbd_q;
    alu_a  = '0;
    alu_b  = '0;
    alu_op = rau_pkg::ALU_ADD;
    unique case (state_q)
      ST_M1: begin
        mul_en = 1'b1;
        mul_a  = man_q;
        mul_b  = (op_q == rau_pkg::OP_MUL) ? mbn_q : mbd_q;
      end
      ST_M2: begin
        mul_en = 1'b1;
        mul_a  = mad_q;
        mul_b  = (op_q == rau_pkg::OP_DIV) ? mbn_q : mbd_q;
      end
      ST_M3: begin
        mul_en = 1'b1;
        mul_a  = mbn_q;
        mul_b  = mad_q;
      end
      ST_ADD: begin
        alu_a  = {1'b0, mn_q};
        alu_b  = {1'b0, prod};
        alu_op = (sn_q == t2s) ? rau_pkg::ALU_ADD : rau_pkg::ALU_SUB;
      end
      ST_ADD2: begin
        alu_a  = {1'b0, prod};
        alu_b  = {1'b0, mn_q};
        alu_op = rau_pkg::ALU_SUB;
      end
      ST_GCD: begin
        alu_a  = {1'b0, x_q};
        alu_b  = {1'b0, y_q};
        alu_op = rau_pkg::ALU_SUB;
      end
      ST_DIVN: begin
        alu_a  = {rem_q, mn_q[MW-1]};
        alu_b  = {1'b0, x_q};
        alu_op = rau_pkg::ALU_SUB;
      end
      ST_DIVD: begin
        alu_a  = {rem_q, md_q[MW-1]};
        alu_b  = {1'b0, x_q};
        alu_op = rau_pkg::ALU_SUB;
      end
      ST_DONE: begin
        alu_a  = '0;
        alu_b  = {1'b0, mn_q};
        alu_op = rau_pkg::ALU_SUB;
      end
      default: begin
      end
    endcase
  end

  // Signed result: negate the reduced numerator when exactly one part was negative.
  assign num_out = ((sn_q ^ sd_q) & (mn_q != '0)) ? alu_res : {1'b0, mn_q};

  // Sequencer and datapath next values.
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    san_d   = san_q;
    sad_d   = sad_q;
    sbn_d   = sbn_q;
    sbd_d   = sbd_q;
    man_d   = man_q;
    mad_d   = mad_q;
    mbn_d   = mbn_q;
    mbd_d   = mbd_q;
    sn_d    = sn_q;
    sd_d    = sd_q;
    mn_d    = mn_q;
    md_d    = md_q;
    x_d     = x_q;
    y_d     = y_q;
    rem_d   = rem_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_d    = rau_pkg::op_e'(s_axis_tdata[1:0]);
          san_d   = in_an[W-1];
          sad_d   = in_ad[W-1];
          sbn_d   = in_bn[W-1];
          sbd_d   = in_bd[W-1];
          man_d   = in_an[W-1] ? (~in_an + W'(1)) : in_an;
          mad_d   = in_ad[W-1] ? (~in_ad + W'(1)) : in_ad;
          mbn_d   = in_bn[W-1] ? (~in_bn + W'(1)) : in_bn;
          mbd_d   = in_bd[W-1] ? (~in_bd + W'(1)) : in_bd;
          state_d = ST_M1;
        end
      end
      ST_M1: begin
        state_d = ST_M2;
      end
      ST_M2: begin
        // First product is the numerator, or its first term.
        mn_d    = prod;
        sn_d    = (prod != '0) & (san_q ^ ((op_q == rau_pkg::OP_MUL) ? sbn_q : sbd_q));
        state_d = ST_M3;
      end
      ST_M3: begin
        md_d    = prod;
        sd_d    = (prod != '0) & (sad_q ^ ((op_q == rau_pkg::OP_DIV) ? sbn_q : sbd_q));
        state_d = ((op_q == rau_pkg::OP_ADD) || (op_q == rau_pkg::OP_SUB)) ? ST_ADD : ST_GINIT;
      end
      ST_ADD: begin
        // Same signs add; different signs subtract, redone the other way on a borrow.
        if (alu_flags.borrow) begin
          state_d = ST_ADD2;
        end else begin
          mn_d    = alu_res[MW-1:0];
          state_d = ST_GINIT;
        end
      end
      ST_ADD2: begin
        mn_d    = alu_res[MW-1:0];
        sn_d    = t2s;
        state_d = ST_GINIT;
      end
      ST_GINIT: begin
        x_d     = mn_q;
        y_d     = md_q;
        k_d     = '0;
        state_d = ST_GCD;
      end
      ST_GCD: begin
        // Binary gcd: one halving, subtraction or swap per cycle.
        if ((x_q == '0) && (y_q == '0)) begin
          x_d     = MW'(1);
          state_d = ST_SHL;
        end else if (x_q == '0) begin
          x_d     = y_q;
          state_d = ST_SHL;
        end else if ((y_q == '0) || alu_flags.zero) begin
          state_d = ST_SHL;
        end else if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + KW'(1);
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (!alu_flags.borrow) begin
          x_d = alu_res[MW-1:0];
        end else begin
          x_d = y_q;
          y_d = x_q;
        end
      end
      ST_SHL: begin
        // Restore the common factors of two to the gcd.
        if (k_q == '0) begin
          rem_d   = '0;
          cnt_d   = CW'(MW);
          state_d = ST_DIVN;
        end else begin
          x_d = x_q << 1;
          k_d = k_q - KW'(1);
        end
      end
      ST_DIVN: begin
        // Restoring division, quotient bits shift into the dividend register.
        rem_d = alu_flags.borrow ? alu_a[MW-1:0] : alu_res[MW-1:0];
        mn_d  = {mn_q[MW-2:0], div_bit};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          rem_d   = '0;
          cnt_d   = CW'(MW);
          state_d = ST_DIVD;
        end
      end
      ST_DIVD: begin
        rem_d = alu_flags.borrow ? alu_a[MW-1:0] : alu_res[MW-1:0];
        md_d  = {md_q[MW-2:0], div_bit};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register contents.
  assign m_data_d  = OUT_PAD'({md_q[DEN_W-1:0], num_out});
  assign m_user_d  = (md_q == '0);
  assign m_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_q       <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    san_q <= san_d;
    sad_q <= sad_d;
    sbn_q <= sbn_d;
    sbd_q <= sbd_d;
    man_q <= man_d;
    mad_q <= mad_d;
    mbn_q <= mbn_d;
    mbd_q <= mbd_d;
    sn_q  <= sn_d;
    sd_q  <= sd_d;
    mn_q  <= mn_d;
    md_q  <= md_d;
    x_q   <= x_d;
    y_q   <= y_d;
    rem_q <= rem_d;
    if (out_load) begin
      m_data_q <= m_data_d;
      m_user_q <= m_user_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

### rtl/core/rau_checker.sv
module rau_checker #(
  parameter int OPERAND_BITS = 16
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tvalid,
  input logic                                  s_axis_tready,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  input logic [((4*OPERAND_BITS+7)/8)*8-1:0]   m_axis_tdata,
  input logic                                  m_axis_tuser
);

  localparam int NUM_W = 2 * OPERAND_BITS + 1;
  localparam int DEN_W = 2 * OPERAND_BITS - 1;

  logic [NUM_W-1:0] res_num;
  logic [DEN_W-1:0] res_den;

  assign res_num = m_axis_tdata[NUM_W-1:0];
  assign res_den = m_axis_tdata[NUM_W +: DEN_W];

  // The unit works on one transaction at a time: it is busy right after a start.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a transaction was in progress");

  // The undefined flag matches a zero denominator.
  a_undef_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == (res_den == '0)))
    else $error("undefined flag disagrees with the denominator");

  // A defined zero result is reduced to zero over one.
  a_zero_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser && (res_num == '0)) |-> (res_den == DEN_W'(1)))
    else $error("zero result not reduced to zero over one");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind rational_arithmetic_unit_top rau_checker #(
  .OPERAND_BITS(OPERAND_BITS)
) u_rau_checker (.*);
